@@ rtl/prd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prd_pkg
// Shared types, register indexes and saturation helpers for the pinhole ray
// direction unit.
// ----------------------------------------------------------------------------
package prd_pkg;

  localparam int PIX_IDX_W   = 12;
  localparam int ENTRY_W     = 18;
  localparam int ROW_W       = 3 * ENTRY_W;
  localparam int COORD_W     = 32;
  localparam int PITCH_W     = 31;
  localparam int CFG_INDEX_W = 3;

  localparam int DEF_INDEX_BITS = 12;
  localparam int DEF_FRAC_BITS  = 16;

  // Register indexes on the config port.
  localparam logic [CFG_INDEX_W-1:0] REG_MATRIX_ROW0 = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MATRIX_ROW1 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MATRIX_ROW2 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_START_X     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_START_Y     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_PITCH = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_FOCAL_DEPTH = 3'd6;

  typedef struct packed {
    logic [PIX_IDX_W-1:0] pixel_row;
    logic [PIX_IDX_W-1:0] pixel_col;
  } pixel_req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] dir_x;
    logic signed [COORD_W-1:0] dir_y;
    logic signed [COORD_W-1:0] dir_z;
  } ray_dir_t;

  localparam logic signed [COORD_W-1:0] SAT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] SAT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // Clamp a 45-bit signed value to 32 bits.
  function automatic logic signed [COORD_W-1:0] sat_45(input logic signed [44:0] v);
    logic ovf;
    ovf = !((&v[44:COORD_W-1]) || !(|v[44:COORD_W-1]));
    if (ovf) begin
      sat_45 = v[44] ? SAT_MIN : SAT_MAX;
    end else begin
      sat_45 = v[COORD_W-1:0];
    end
  endfunction

  // Clamp a 52-bit signed value to 32 bits.
  function automatic logic signed [COORD_W-1:0] sat_52(input logic signed [51:0] v);
    logic ovf;
    ovf = !((&v[51:COORD_W-1]) || !(|v[51:COORD_W-1]));
    if (ovf) begin
      sat_52 = v[51] ? SAT_MIN : SAT_MAX;
    end else begin
      sat_52 = v[COORD_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

@@ rtl/prd_dot.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prd_dot
// One matrix row times the camera-space vector: three products, a sum, then
// a floor shift and clamp. Three register stages.
// ----------------------------------------------------------------------------
module prd_dot #(
  parameter int FRAC_BITS = prd_pkg::DEF_FRAC_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                valid_in,
  input  wire logic [prd_pkg::ROW_W-1:0]           row,
  input  wire logic signed [prd_pkg::COORD_W-1:0]  vx,
  input  wire logic signed [prd_pkg::COORD_W-1:0]  vy,
  input  wire logic signed [prd_pkg::COORD_W-1:0]  vz,
  output logic                                     valid_out,
  output logic signed [prd_pkg::COORD_W-1:0]       dir
);
  import prd_pkg::*;

  logic signed [ENTRY_W-1:0] e0, e1, e2;
  logic signed [49:0]        p0, p1, p2;
  logic signed [51:0]        acc;
  logic signed [51:0]        acc_shr;
  logic                      p_valid, acc_valid;

  assign e0 = signed'(row[ENTRY_W-1:0]);
  assign e1 = signed'(row[2*ENTRY_W-1:ENTRY_W]);
  assign e2 = signed'(row[3*ENTRY_W-1:2*ENTRY_W]);

  assign acc_shr = acc >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      acc_valid <= 1'b0;
      valid_out <= 1'b0;
    end else begin
      p_valid   <= valid_in;
      acc_valid <= p_valid;
      valid_out <= acc_valid;
    end
  end

  always_ff @(posedge clk) begin
    p0  <= 50'(e0) * 50'(vx);
    p1  <= 50'(e1) * 50'(vy);
    p2  <= 50'(e2) * 50'(vz);
    acc <= 52'(p0) + 52'(p1) + 52'(p2);
    dir <= sat_52(acc_shr);
  end

endmodule
`default_nettype wire

@@ rtl/pinhole_ray_direction_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pinhole_ray_direction_unit
// Pixel (row, col) in, rotated camera-space ray direction out.
//
//   channel  | handshake          | word
//   ---------+--------------------+------------------------------------
//   pixel    | start / busy       | req    : pixel_row, pixel_col
//   ray      | done (strobe)      | result : dir_x, dir_y, dir_z
//   config   | cfg_we             | cfg_index, cfg_data
//
// Six register stages: input, pitch multiply, offset add and clamp, matrix
// multiply, sum, shift and clamp; a taken word leaves them on result with
// done high. One word per cycle; busy is high only during reset. rst clears
// the valid chain and loads the identity matrix, zero start offsets and unit
// pitch and depth. The receiver cannot stall.
// ----------------------------------------------------------------------------
module pinhole_ray_direction_unit #(
  parameter int INDEX_BITS = prd_pkg::DEF_INDEX_BITS,
  parameter int FRAC_BITS  = prd_pkg::DEF_FRAC_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire prd_pkg::pixel_req_t               req,
  output logic                                   done,
  output prd_pkg::ray_dir_t                      result,
  input  wire logic                              cfg_we,
  input  wire logic [prd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [prd_pkg::ROW_W-1:0]         cfg_data
);
  import prd_pkg::*;

  localparam logic [PIX_IDX_W-1:0] IDX_MASK =
    (INDEX_BITS >= PIX_IDX_W) ? {PIX_IDX_W{1'b1}} : PIX_IDX_W'((1 << INDEX_BITS) - 1);
  localparam logic [ROW_W-1:0]   ROW0_RESET  = ROW_W'(1) << FRAC_BITS;
  localparam logic [ROW_W-1:0]   ROW1_RESET  = ROW_W'(1) << (FRAC_BITS + ENTRY_W);
  localparam logic [ROW_W-1:0]   ROW2_RESET  = ROW_W'(1) << (FRAC_BITS + 2 * ENTRY_W);
  localparam logic [PITCH_W-1:0] UNIT_RESET  = PITCH_W'(1) << FRAC_BITS;

  // config registers
  logic [ROW_W-1:0]          matrix_row0, matrix_row1, matrix_row2;
  logic signed [COORD_W-1:0] start_x, start_y;
  logic [PITCH_W-1:0]        pixel_pitch, focal_depth;

  // pipeline
  logic                      s1_valid, s2_valid, s3_valid;
  logic [PIX_IDX_W-1:0]      s1_row, s1_col;
  logic [42:0]               s2_py, s2_px;
  logic signed [COORD_W-1:0] s3_x, s3_y, s3_z;
  logic signed [44:0]        sum_x, sum_y;
  logic [2:0]                dot_valid;
  logic                      accept;

  assign busy   = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_row0 <= ROW0_RESET;
      matrix_row1 <= ROW1_RESET;
      matrix_row2 <= ROW2_RESET;
      start_x     <= '0;
      start_y     <= '0;
      pixel_pitch <= UNIT_RESET;
      focal_depth <= UNIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MATRIX_ROW0: matrix_row0 <= cfg_data;
        REG_MATRIX_ROW1: matrix_row1 <= cfg_data;
        REG_MATRIX_ROW2: matrix_row2 <= cfg_data;
        REG_START_X:     start_x     <= signed'(cfg_data[COORD_W-1:0]);
        REG_START_Y:     start_y     <= signed'(cfg_data[COORD_W-1:0]);
        REG_PIXEL_PITCH: pixel_pitch <= cfg_data[PITCH_W-1:0];
        REG_FOCAL_DEPTH: focal_depth <= cfg_data[PITCH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  assign sum_x = 45'(start_x) + signed'({2'b00, s2_px});
  assign sum_y = 45'(start_y) + signed'({2'b00, s2_py});

  always_ff @(posedge clk) begin
    s1_row <= req.pixel_row & IDX_MASK;
    s1_col <= req.pixel_col & IDX_MASK;
    s2_px  <= 43'(s1_col) * 43'(pixel_pitch);
    s2_py  <= 43'(s1_row) * 43'(pixel_pitch);
    s3_x   <= sat_45(sum_x);
    s3_y   <= sat_45(sum_y);
    s3_z   <= signed'({1'b0, focal_depth});
  end

  prd_dot #(.FRAC_BITS(FRAC_BITS)) u_dot_x (
    .clk(clk), .rst(rst), .valid_in(s3_valid), .row(matrix_row0),
    .vx(s3_x), .vy(s3_y), .vz(s3_z), .valid_out(dot_valid[0]), .dir(result.dir_x)
  );

  prd_dot #(.FRAC_BITS(FRAC_BITS)) u_dot_y (
    .clk(clk), .rst(rst), .valid_in(s3_valid), .row(matrix_row1),
    .vx(s3_x), .vy(s3_y), .vz(s3_z), .valid_out(dot_valid[1]), .dir(result.dir_y)
  );

  prd_dot #(.FRAC_BITS(FRAC_BITS)) u_dot_z (
    .clk(clk), .rst(rst), .valid_in(s3_valid), .row(matrix_row2),
    .vx(s3_x), .vy(s3_y), .vz(s3_z), .valid_out(dot_valid[2]), .dir(result.dir_z)
  );

  assign done = dot_valid[0];

  // checks
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##6 done)
    else $error("accepted word did not complete after six cycles");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 6))
    else $error("done without a matching accepted word");

  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    (dot_valid == 3'b000) || (dot_valid == 3'b111))
    else $error("dot product lanes out of step");

  a_reset_flush: assert property (@(posedge clk)
    rst |=> !done)
    else $error("done right after reset");

endmodule
`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pinhole ray direction unit. Pixel words are
// driven with random gaps and checked in order against an in-bench model of
// the pitch scaling, offset clamp and matrix rotation with floor and
// saturation. Each configuration phase starts only once the block has
// drained.
// ----------------------------------------------------------------------------
module tb;
  import prd_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [ENTRY_W-1:0] ENTRY_POS_MAX = 18'h1FFFF;
  localparam logic [ENTRY_W-1:0] ENTRY_NEG_MAX = 18'h20000;
  localparam logic [COORD_W-1:0] COORD_MAX = 32'h7FFFFFFF;
  localparam logic [COORD_W-1:0] COORD_MIN = 32'h80000000;
  localparam logic [PITCH_W-1:0] PITCH_MAX = 31'h7FFFFFFF;
  localparam logic [PIX_IDX_W-1:0] IDX_MAX = 12'hFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  pixel_req_t req = '0;
  logic done;
  ray_dir_t result;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [ROW_W-1:0] cfg_data = '0;

  // shadow copy of the camera registers
  logic [ROW_W-1:0] mat_row [3];
  logic signed [COORD_W-1:0] cam_start_x = '0;
  logic signed [COORD_W-1:0] cam_start_y = '0;
  logic [PITCH_W-1:0] cam_pitch = 31'h10000;
  logic [PITCH_W-1:0] cam_focal = 31'h10000;

  pixel_req_t pending_pixels [$];
  ray_dir_t expected_rays [$];
  ray_dir_t want_ray;
  int err_count = 0;
  int gap_left = 0;
  bit burst_mode = 1'b0;

  pinhole_ray_direction_unit uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .done(done),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clamp_q15(longint v);
    longint hi, lo;
    hi = SAT_MAX;
    lo = SAT_MIN;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint rotate_row(logic [ROW_W-1:0] row, longint x, longint y,
                                        longint z);
    longint e0, e1, e2;
    e0 = $signed(row[ENTRY_W-1:0]);
    e1 = $signed(row[2*ENTRY_W-1:ENTRY_W]);
    e2 = $signed(row[3*ENTRY_W-1:2*ENTRY_W]);
    return clamp_q15((e0 * x + e1 * y + e2 * z) >>> DEF_FRAC_BITS);
  endfunction

  function automatic ray_dir_t predict_ray(pixel_req_t px);
    longint col, row, pitch, sx, sy, x, y, z;
    ray_dir_t r;
    col = px.pixel_col;
    row = px.pixel_row;
    pitch = cam_pitch;
    sx = cam_start_x;
    sy = cam_start_y;
    x = clamp_q15(sx + col * pitch);
    y = clamp_q15(sy + row * pitch);
    z = cam_focal;
    r.dir_x = COORD_W'(rotate_row(mat_row[0], x, y, z));
    r.dir_y = COORD_W'(rotate_row(mat_row[1], x, y, z));
    r.dir_z = COORD_W'(rotate_row(mat_row[2], x, y, z));
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [PIX_IDX_W-1:0] pick_index();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return IDX_MAX;
      default: return PIX_IDX_W'($urandom_range(0, IDX_MAX));
    endcase
  endfunction

  function automatic logic [ROW_W-1:0] random_row();
    logic [ROW_W-1:0] r;
    int v;
    r = ROW_W'({$urandom, $urandom});
    if ($urandom_range(0, 2) != 0) begin
      for (int k = 0; k < 3; k++) begin
        case ($urandom_range(0, 7))
          0: r[k*ENTRY_W +: ENTRY_W] = ENTRY_POS_MAX;
          1: r[k*ENTRY_W +: ENTRY_W] = ENTRY_NEG_MAX;
          default: begin
            v = int'($urandom_range(0, 131072)) - 65536;
            r[k*ENTRY_W +: ENTRY_W] = v[ENTRY_W-1:0];
          end
        endcase
      end
    end
    return r;
  endfunction

  // low bits carry the value, bits above the register width are junk
  function automatic logic [ROW_W-1:0] random_offset();
    logic [ROW_W-1:0] d;
    int v;
    d = ROW_W'({$urandom, $urandom});
    if ($urandom_range(0, 2) != 0) begin
      v = int'($urandom_range(0, 1 << 25)) - (1 << 24);
      d[COORD_W-1:0] = v;
    end
    return d;
  endfunction

  function automatic logic [ROW_W-1:0] random_length();
    logic [ROW_W-1:0] d;
    d = ROW_W'({$urandom, $urandom});
    if ($urandom_range(0, 2) != 0) d[PITCH_W-1:0] = PITCH_W'($urandom_range(0, 1 << 18));
    return d;
  endfunction

  task automatic report_mismatch(string what, logic [COORD_W-1:0] got,
                                 logic [COORD_W-1:0] want);
    if (err_count < 40) begin
      $display("%0t mismatch %s: got %0d want %0d", $realtime, what, $signed(got),
               $signed(want));
    end
    err_count++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy) expected_rays.push_back(predict_ray(req));
      if (start && busy) begin
        // hold the word
      end else if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_pixels.size() != 0) begin
        start <= 1'b1;
        req <= pending_pixels.pop_front();
        gap_left <= pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_rays.size() == 0) begin
        report_mismatch("unexpected word", result.dir_x, '0);
      end else begin
        want_ray = expected_rays.pop_front();
        if (result.dir_x !== want_ray.dir_x) report_mismatch("dir_x", result.dir_x, want_ray.dir_x);
        if (result.dir_y !== want_ray.dir_y) report_mismatch("dir_y", result.dir_y, want_ray.dir_y);
        if (result.dir_z !== want_ray.dir_z) report_mismatch("dir_z", result.dir_z, want_ray.dir_z);
      end
    end
  end

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [ROW_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_MATRIX_ROW0: mat_row[0] = data;
      REG_MATRIX_ROW1: mat_row[1] = data;
      REG_MATRIX_ROW2: mat_row[2] = data;
      REG_START_X:     cam_start_x = data[COORD_W-1:0];
      REG_START_Y:     cam_start_y = data[COORD_W-1:0];
      REG_PIXEL_PITCH: cam_pitch = data[PITCH_W-1:0];
      REG_FOCAL_DEPTH: cam_focal = data[PITCH_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_camera(logic [ROW_W-1:0] r0, logic [ROW_W-1:0] r1,
                              logic [ROW_W-1:0] r2, logic [ROW_W-1:0] sx,
                              logic [ROW_W-1:0] sy, logic [ROW_W-1:0] pitch,
                              logic [ROW_W-1:0] focal);
    write_reg(REG_MATRIX_ROW0, r0);
    write_reg(REG_MATRIX_ROW1, r1);
    write_reg(REG_MATRIX_ROW2, r2);
    write_reg(REG_START_X, sx);
    write_reg(REG_START_Y, sy);
    write_reg(REG_PIXEL_PITCH, pitch);
    write_reg(REG_FOCAL_DEPTH, focal);
  endtask

  task automatic queue_pixel(logic [PIX_IDX_W-1:0] row, logic [PIX_IDX_W-1:0] col);
    pending_pixels.push_back('{pixel_row: row, pixel_col: col});
  endtask

  task automatic queue_corners();
    queue_pixel('0, '0);
    queue_pixel(IDX_MAX, IDX_MAX);
    queue_pixel('0, IDX_MAX);
    queue_pixel(IDX_MAX, '0);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_pixels.size() != 0 || start || expected_rays.size() != 0) @(negedge clk);
  endtask

  initial begin
    mat_row[0] = ROW_W'(1) << DEF_FRAC_BITS;
    mat_row[1] = ROW_W'(1) << (DEF_FRAC_BITS + ENTRY_W);
    mat_row[2] = ROW_W'(1) << (DEF_FRAC_BITS + 2 * ENTRY_W);
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset camera: identity, unit pitch and depth
    queue_corners();
    queue_pixel(12'd1, 12'd2);
    wait_idle();

    // largest positive entries and lengths, extreme offsets: clamp before and after rotation
    write_camera({3{ENTRY_POS_MAX}}, {3{ENTRY_POS_MAX}}, {3{ENTRY_POS_MAX}},
                 {22'h3FFFFF, COORD_MIN}, {22'h3FFFFF, COORD_MAX},
                 {23'h7FFFFF, PITCH_MAX}, {23'h7FFFFF, PITCH_MAX});
    queue_corners();
    wait_idle();

    // most negative entries
    write_camera({3{ENTRY_NEG_MAX}}, {3{ENTRY_NEG_MAX}}, {3{ENTRY_NEG_MAX}},
                 {22'd0, COORD_MAX}, {22'd0, COORD_MIN}, {23'd0, PITCH_MAX},
                 {23'd0, PITCH_MAX});
    queue_corners();
    wait_idle();

    // tiny negative sums must floor toward minus infinity
    write_camera({36'd0, 18'd1}, {18'd0, 18'h3FFFF, 18'd0}, {18'd3, 36'd0},
                 {22'd0, 32'hFFFFFFFF}, {22'd0, 32'd5}, {23'd0, 31'd3},
                 {23'd0, 31'd7});
    queue_pixel('0, '0);
    queue_pixel(12'd1, 12'd0);
    queue_pixel(12'd0, 12'd1);
    wait_idle();

    // all zero; a write to the spare index changes nothing
    write_camera('0, '0, '0, '0, '0, '0, '0);
    write_reg(REG_UNUSED, '1);
    queue_pixel(IDX_MAX, 12'd7);
    queue_pixel(12'd9, IDX_MAX);
    wait_idle();

    for (int phase = 0; phase < 8; phase++) begin
      write_camera(random_row(), random_row(), random_row(), random_offset(),
                   random_offset(), random_length(), random_length());
      burst_mode = (phase == 3);
      for (int i = 0; i < 80; i++) queue_pixel(pick_index(), pick_index());
      wait_idle();
    end

    repeat (12) @(posedge clk);
    if (err_count == 0) begin
      $display("[pinhole_ray_direction_unit] OK");
    end else begin
      $display("[pinhole_ray_direction_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[pinhole_ray_direction_unit] ERROR");
    $finish;
  end

endmodule
